// ===== hw/rtl/crsp_pkg.sv =====
package crsp_pkg;

    // Width of every control value, parameter and result.
    localparam int DATA_W = 32;

    typedef logic signed [DATA_W-1:0] sample_t;

    // Saturation limits of the result.
    localparam sample_t SAT_MAX = 32'sh7fff_ffff;
    localparam sample_t SAT_MIN = 32'sh8000_0000;

    // How the result of a transaction is chosen.
    typedef enum logic [1:0] {
        SEL_START,  // parameter at or below zero: segment start
        SEL_END,    // parameter at or above one: segment end
        SEL_CURVE   // parameter inside the segment: weighted sum
    } sel_t;

    // Control that travels with a transaction between the two halves.
    typedef struct packed {
        logic valid;
        sel_t sel;
    } ctl_t;

endpackage

// ===== hw/rtl/crsp_basis.sv =====
module crsp_basis #(
    parameter int FRAC_BITS = 16,
    localparam int WW = FRAC_BITS + 5
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         item_valid,
    output logic                         item_ready,
    input  crsp_pkg::sample_t            point_before,
    input  crsp_pkg::sample_t            segment_start,
    input  crsp_pkg::sample_t            segment_end,
    input  crsp_pkg::sample_t            point_after,
    input  crsp_pkg::sample_t            position,
    output crsp_pkg::ctl_t               basis_ctl,
    input  logic                         basis_ready,
    output crsp_pkg::sample_t            pts [4],
    output logic signed [WW-1:0]         wts [4]
);

    localparam int F   = FRAC_BITS;
    localparam int PW2 = 2 * F;
    localparam crsp_pkg::sample_t ONE = crsp_pkg::sample_t'(1) <<< F;
    localparam logic [PW2:0] HALF = (PW2 + 1)'(1) << (F - 1);
    localparam logic signed [WW-1:0] TWO_ONE = WW'(1) <<< (F + 1);

    // stage valids and flow control
    logic v1_reg, v2_reg, v3_reg;
    logic rdy1, rdy2, rdy3;

    // stage payload
    crsp_pkg::sel_t    sel1_reg, sel2_reg, sel3_reg;
    crsp_pkg::sample_t pts1_reg [4];
    crsp_pkg::sample_t pts2_reg [4];
    crsp_pkg::sample_t pts3_reg [4];
    logic [F-1:0]      tf1_reg, tf2_reg;
    logic [PW2-1:0]    tt1_reg;
    logic [F:0]        t2_reg;
    logic [PW2:0]      t2t_reg;
    logic signed [WW-1:0] wts3_reg [4];

    // next values
    crsp_pkg::sel_t       sel1_next;
    logic [F-1:0]         tf1_next;
    logic [PW2-1:0]       tt1_next;
    logic [PW2:0]         t2_full;
    logic [F:0]           t2_next;
    logic [PW2:0]         t2t_next;
    logic [PW2+1:0]       t3_full;
    logic [F:0]           t3;
    logic signed [WW-1:0] t_s, t2_s, t3_s;
    logic signed [WW-1:0] wts3_next [4];

    assign rdy3       = !v3_reg || basis_ready;
    assign rdy2       = !v2_reg || rdy3;
    assign rdy1       = !v1_reg || rdy2;
    assign item_ready = rdy1;

    // stage 1: range check and t*t
    always_comb
    begin
        priority if (position <= 0)
            sel1_next = crsp_pkg::SEL_START;
        else if (position >= ONE)
            sel1_next = crsp_pkg::SEL_END;
        else
            sel1_next = crsp_pkg::SEL_CURVE;
    end

    assign tf1_next = position[F-1:0];
    assign tt1_next = PW2'(tf1_next) * PW2'(tf1_next);

    // stage 2: round t^2, then t^2*t
    assign t2_full  = {1'b0, tt1_reg} + HALF;
    assign t2_next  = t2_full[PW2:F];
    assign t2t_next = (PW2 + 1)'(t2_next) * (PW2 + 1)'(tf1_reg);

    // stage 3: round t^3, doubled basis weights
    assign t3_full = {1'b0, t2t_reg} + (PW2 + 2)'(HALF);
    assign t3      = t3_full[PW2:F];
    assign t_s     = signed'(WW'(tf2_reg));
    assign t2_s    = signed'(WW'(t2_reg));
    assign t3_s    = signed'(WW'(t3));

    always_comb
    begin
        wts3_next[0] = -t3_s + (t2_s <<< 1) - t_s;
        wts3_next[1] = (t3_s <<< 1) + t3_s - (t2_s <<< 2) - t2_s + TWO_ONE;
        wts3_next[2] = -(t3_s <<< 1) - t3_s + (t2_s <<< 2) + t_s;
        wts3_next[3] = t3_s - t2_s;
    end

    // valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            if (rdy1)
                v1_reg <= item_valid;
            if (rdy2)
                v2_reg <= v1_reg;
            if (rdy3)
                v3_reg <= v2_reg;
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (rdy1 && item_valid)
        begin
            sel1_reg    <= sel1_next;
            pts1_reg[0] <= point_before;
            pts1_reg[1] <= segment_start;
            pts1_reg[2] <= segment_end;
            pts1_reg[3] <= point_after;
            tf1_reg     <= tf1_next;
            tt1_reg     <= tt1_next;
        end
        if (rdy2 && v1_reg)
        begin
            sel2_reg <= sel1_reg;
            pts2_reg <= pts1_reg;
            tf2_reg  <= tf1_reg;
            t2_reg   <= t2_next;
            t2t_reg  <= t2t_next;
        end
        if (rdy3 && v2_reg)
        begin
            sel3_reg <= sel2_reg;
            pts3_reg <= pts2_reg;
            wts3_reg <= wts3_next;
        end
    end

    assign basis_ctl.valid = v3_reg;
    assign basis_ctl.sel   = sel3_reg;
    assign pts             = pts3_reg;
    assign wts             = wts3_reg;

    // doubled weights always sum to two
    a_unity: assert property (@(posedge clk) disable iff (!rst_n)
        v3_reg && sel3_reg == crsp_pkg::SEL_CURVE |->
        (wts3_reg[0] + wts3_reg[1] + wts3_reg[2] + wts3_reg[3]) == TWO_ONE)
        else $error("basis weights do not sum to two");

    // a held stage keeps its middle two weights
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        v3_reg && !basis_ready |=> v3_reg && $stable(wts3_reg[1])
        && $stable(wts3_reg[2]))
        else $error("stalled basis stage changed");

endmodule

// ===== hw/rtl/crsp_blend.sv =====
module crsp_blend #(
    parameter int FRAC_BITS = 16,
    localparam int WW = FRAC_BITS + 5
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  crsp_pkg::ctl_t       basis_ctl,
    output logic                 basis_ready,
    input  crsp_pkg::sample_t    pts [4],
    input  logic signed [WW-1:0] wts [4],
    output logic                 out_valid,
    input  logic                 out_stall,
    output crsp_pkg::sample_t    curve_value
);

    localparam int F  = FRAC_BITS;
    localparam int PW = crsp_pkg::DATA_W + WW;
    localparam int TW = PW - F - 1;
    localparam int SW = TW + 2;
    localparam logic signed [PW-1:0] HALF = PW'(1) <<< F;

    logic rdy4, rdy5;
    logic v4_reg, out_valid_reg;

    crsp_pkg::sel_t       sel4_reg;
    crsp_pkg::sample_t    pass4_reg;
    logic signed [PW-1:0] prod4_reg [4];
    crsp_pkg::sample_t    curve_value_reg;

    crsp_pkg::sample_t    pass4_next;
    logic signed [PW-1:0] prod4_next [4];
    logic signed [PW-1:0] rnd [4];
    logic signed [TW-1:0] term [4];
    logic signed [SW-1:0] sum;
    crsp_pkg::sample_t    curve_value_next;

    assign rdy5        = !out_valid_reg || !out_stall;
    assign rdy4        = !v4_reg || rdy5;
    assign basis_ready = rdy4;

    // stage 4: four products, passthrough value for clamped parameters
    always_comb
    begin
        for (int i = 0; i < 4; i++)
        begin
            prod4_next[i] = PW'(pts[i]) * PW'(wts[i]);
        end
        pass4_next = (basis_ctl.sel == crsp_pkg::SEL_START) ? pts[1] : pts[2];
    end

    // stage 5: round each term, sum, saturate
    always_comb
    begin
        for (int i = 0; i < 4; i++)
        begin
            rnd[i]  = prod4_reg[i] + HALF;
            term[i] = TW'(rnd[i] >>> (F + 1));
        end
        sum = SW'(term[0]) + SW'(term[1]) + SW'(term[2]) + SW'(term[3]);
        priority if (sel4_reg != crsp_pkg::SEL_CURVE)
            curve_value_next = pass4_reg;
        else if (sum > SW'(crsp_pkg::SAT_MAX))
            curve_value_next = crsp_pkg::SAT_MAX;
        else if (sum < SW'(crsp_pkg::SAT_MIN))
            curve_value_next = crsp_pkg::SAT_MIN;
        else
            curve_value_next = crsp_pkg::DATA_W'(sum);
    end

    // valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v4_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (rdy4)
                v4_reg <= basis_ctl.valid;
            if (rdy5)
                out_valid_reg <= v4_reg;
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (rdy4 && basis_ctl.valid)
        begin
            sel4_reg  <= basis_ctl.sel;
            pass4_reg <= pass4_next;
            prod4_reg <= prod4_next;
        end
        if (rdy5 && v4_reg)
            curve_value_reg <= curve_value_next;
    end

    assign out_valid   = out_valid_reg;
    assign curve_value = curve_value_reg;

    // clamped parameters return a control value unchanged
    a_pass: assert property (@(posedge clk) disable iff (!rst_n)
        v4_reg && rdy5 && sel4_reg != crsp_pkg::SEL_CURVE |=>
        out_valid_reg && curve_value_reg == $past(pass4_reg))
        else $error("clamped result differs from control value");

    // a blocked product stage keeps its transaction
    a_keep: assert property (@(posedge clk) disable iff (!rst_n)
        v4_reg && !rdy5 |=> v4_reg && $stable(prod4_reg[0]))
        else $error("product stage lost a transaction");

endmodule

// ===== hw/rtl/catmull_rom_spline_point_unit.sv =====
// Uniform Catmull-Rom spline point, one scalar component per transaction.
// Input channel: in_valid / in_stall with point_before, segment_start,
// segment_end, point_after and position (t), all signed fixed point with
// FRAC_BITS fraction bits. Output channel: out_valid / out_stall with
// curve_value, saturated to the 32-bit range. A 3D point is three
// transactions, one per component.
// Pipeline: five register stages. Throughput: one transaction per cycle
// while out_stall is low. The three multiplies (t*t, t^2*t, control
// value times weight) each get a stage of their own; the rounding of
// t^3 with the weight adds, and the final rounding, sum and
// saturation, take the other two stages.
// Stall: the output register holds its result while out_stall is high;
// earlier stages keep filling empty slots, so in_stall rises only once
// every stage holds a transaction.
// Reset (rst_n, asynchronous, active low) empties every stage; the block
// accepts input in the first cycle after reset.
module catmull_rom_spline_point_unit #(
    parameter int FRAC_BITS = 16
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  crsp_pkg::sample_t point_before,
    input  crsp_pkg::sample_t segment_start,
    input  crsp_pkg::sample_t segment_end,
    input  crsp_pkg::sample_t point_after,
    input  crsp_pkg::sample_t position,
    output logic              out_valid,
    input  logic              out_stall,
    output crsp_pkg::sample_t curve_value
);

    localparam int WW = FRAC_BITS + 5;

    logic                 item_ready;
    logic                 basis_ready;
    crsp_pkg::ctl_t       basis_ctl;
    crsp_pkg::sample_t    pts [4];
    logic signed [WW-1:0] wts [4];

    assign in_stall = !item_ready;

    // powers of t and basis weights
    crsp_basis #(
        .FRAC_BITS (FRAC_BITS)
    ) u_basis (
        .clk           (clk),
        .rst_n         (rst_n),
        .item_valid    (in_valid),
        .item_ready    (item_ready),
        .point_before  (point_before),
        .segment_start (segment_start),
        .segment_end   (segment_end),
        .point_after   (point_after),
        .position      (position),
        .basis_ctl     (basis_ctl),
        .basis_ready   (basis_ready),
        .pts           (pts),
        .wts           (wts)
    );

    // weighted sum, rounding and saturation
    crsp_blend #(
        .FRAC_BITS (FRAC_BITS)
    ) u_blend (
        .clk         (clk),
        .rst_n       (rst_n),
        .basis_ctl   (basis_ctl),
        .basis_ready (basis_ready),
        .pts         (pts),
        .wts         (wts),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .curve_value (curve_value)
    );

endmodule
